FILE: rtl/mbtrp_pkg.sv
// Shared types, codes and helpers for the Modbus TCP response parser.
package mbtrp_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned PtrW      = 2;
    localparam int unsigned CntW      = 3;

    typedef logic cfg_idx_t;
    localparam cfg_idx_t REG_EXTRA_READ  = 1'b0;
    localparam cfg_idx_t REG_EXTRA_WRITE = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_BITS = 2'd0;
    localparam kind_t KIND_REG  = 2'd1;
    localparam kind_t KIND_DONE = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_EXCEPTION = 3'd1;
    localparam status_t ST_UNKNOWN   = 3'd2;
    localparam status_t ST_PROTO     = 3'd3;
    localparam status_t ST_ID        = 3'd4;

    typedef logic [2:0] cls_t;
    localparam cls_t CLS_UNKNOWN = 3'd0;
    localparam cls_t CLS_BITS    = 3'd1;
    localparam cls_t CLS_REGS    = 3'd2;
    localparam cls_t CLS_XREGS   = 3'd3;
    localparam cls_t CLS_WRITE   = 3'd4;

    localparam logic [6:0] FC_READ_COILS      = 7'd1;
    localparam logic [6:0] FC_READ_INPUTS     = 7'd2;
    localparam logic [6:0] FC_READ_HOLDING    = 7'd3;
    localparam logic [6:0] FC_READ_INPUT_REGS = 7'd4;
    localparam logic [6:0] FC_WRITE_COIL      = 7'd5;
    localparam logic [6:0] FC_WRITE_REG       = 7'd6;
    localparam logic [6:0] FC_WRITE_COILS     = 7'd15;
    localparam logic [6:0] FC_WRITE_REGS      = 7'd16;

    localparam logic [7:0] EXC_BIT_MASK = 8'h80;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [3:0]  bit_count;
        logic [7:0]  unit_id;
        logic [6:0]  function_code;
        status_t     status;
        logic [7:0]  error_code;
        logic        last;
    } result_t;

    function automatic cls_t classify(input logic [6:0] f, input logic [6:0] xr,
                                      input logic [6:0] xw);
        cls_t c;
        c = CLS_UNKNOWN;
        case (f) inside
            FC_READ_COILS, FC_READ_INPUTS:     c = CLS_BITS;
            FC_READ_HOLDING, FC_READ_INPUT_REGS: c = CLS_REGS;
            FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: c = CLS_WRITE;
            default:
            begin
                if (xr != 7'd0 && f == xr)
                begin
                    c = CLS_XREGS;
                end
                else if (xw != 7'd0 && f == xw)
                begin
                    c = CLS_WRITE;
                end
            end
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/mbtrp_in_if.sv
// Byte channel into the response parser.
interface mbtrp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic        frame_start;
    logic [15:0] expected_id;
    logic [10:0] requested_count;

    modport source (output valid, output rx_byte, output frame_start,
                    output expected_id, output requested_count, input ready);
    modport sink   (input valid, input rx_byte, input frame_start,
                    input expected_id, input requested_count, output ready);
endinterface

FILE: rtl/mbtrp_out_if.sv
// Result channel out of the response parser.
interface mbtrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] value;
    logic [3:0]  bit_count;
    logic [7:0]  unit_id;
    logic [6:0]  function_code;
    logic [2:0]  status;
    logic [7:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output value, output bit_count,
                    output unit_id, output function_code, output status,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input value, input bit_count,
                    input unit_id, input function_code, input status,
                    input error_code, input last, output ready);
endinterface

FILE: rtl/modbus_tcp_response_parser_core.sv
// Modbus TCP response parser: header check, data extraction, result queue.
//
// Usage: bytes of a response frame enter on rx, one per beat, with
// frame_start marking the first byte of each frame. Results leave on res:
// packed coil/input bits, 16-bit register values, and one completion or
// error beat (last = 1) per frame. Config writes (cfg_we, cfg_index,
// cfg_data) set the extended read/write function codes; write only while
// idle.
// Timing: the results of a byte are written into the result queue at the
// edge that accepts it, and res is driven from the queue head.
// Throughput: one byte per cycle while each byte gives at most one result
// and res takes every result; a byte giving a data beat and the completion
// beat writes two entries at once. A 4-entry result queue sits between the
// parser and res, and rx is ready while at least two entries are free.
// Reset: clears the frame state, config codes and the queue; the first
// byte after reset is treated as byte 0 of a frame.
// Stall: when res is held off the queue fills and rx.ready drops; no
// result is lost or repeated.
module modbus_tcp_response_parser_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  mbtrp_pkg::cfg_idx_t cfg_index,
    input  logic [6:0]        cfg_data,
    mbtrp_in_if.sink          rx,
    mbtrp_out_if.source       res
);
    import mbtrp_pkg::*;

    logic [6:0]  xread_reg;
    logic [6:0]  xwrite_reg;

    logic [15:0] byte_pos_reg,   byte_pos_next;
    logic [15:0] len_reg,        len_next;
    logic [7:0]  idh_reg,        idh_next;
    logic [7:0]  unit_reg,       unit_next;
    logic [7:0]  func_reg,       func_next;
    logic [7:0]  count_reg,      count_next;
    logic [10:0] elem_reg,       elem_next;
    logic [7:0]  pend_reg,       pend_next;
    logic        discard_reg,    discard_next;

    result_t             fifo_mem [FifoDepth];
    logic [PtrW-1:0]     wp_reg;
    logic [PtrW-1:0]     rp_reg;
    logic [CntW-1:0]     cnt_reg;

    logic        accept;
    logic        active;
    logic        fs;
    logic [7:0]  b;
    logic [15:0] pos;
    logic [15:0] cur_len;
    logic [7:0]  cur_idh;
    logic [7:0]  cur_unit;
    logic [7:0]  cur_func;
    logic [7:0]  cur_count;
    logic [10:0] cur_elem;
    logic [7:0]  cur_pend;
    logic [6:0]  f;
    cls_t        cls;
    logic        id_err;
    logic        proto_err;
    logic        hdr_err;
    logic [10:0] diff;
    logic [3:0]  nbits;
    logic [7:0]  mask;
    logic [15:0] off;
    logic [14:0] lim;
    logic [15:0] len_m3;
    logic [16:0] end_sum;
    logic [15:0] end_pos;
    logic        done;
    logic        v0;
    result_t     r0;
    result_t     r1;
    logic        pop;
    logic        push;
    logic [CntW-1:0] push_n;

    assign fs     = rx.frame_start;
    assign b      = rx.rx_byte;
    assign active = fs || !discard_reg;
    assign accept = rx.valid && rx.ready;
    assign pop    = res.valid && res.ready;
    assign push   = accept && active;

    always_comb
    begin
        pos       = fs ? 16'd0  : byte_pos_reg;
        cur_len   = fs ? 16'd0  : len_reg;
        cur_idh   = fs ? 8'd0   : idh_reg;
        cur_unit  = fs ? 8'd0   : unit_reg;
        cur_func  = fs ? 8'd0   : func_reg;
        cur_count = fs ? 8'd0   : count_reg;
        cur_elem  = fs ? 11'd0  : elem_reg;
        cur_pend  = fs ? 8'd0   : pend_reg;

        idh_next   = (pos == 16'd0) ? b : cur_idh;
        unit_next  = (pos == 16'd6) ? b : cur_unit;
        func_next  = (pos == 16'd7) ? b : cur_func;
        count_next = (pos == 16'd8) ? b : cur_count;
        if (pos == 16'd4)
        begin
            len_next = {b, 8'h00};
        end
        else if (pos == 16'd5)
        begin
            len_next = {cur_len[15:8], b};
        end
        else
        begin
            len_next = cur_len;
        end

        f   = func_next[6:0];
        cls = classify(f, xread_reg, xwrite_reg);

        id_err    = (pos == 16'd1) && ({cur_idh, b} != rx.expected_id);
        proto_err = ((pos == 16'd2) || (pos == 16'd3)) && (b != 8'd0);
        hdr_err   = id_err || proto_err;

        // coil / input bit group
        diff  = rx.requested_count - cur_elem;
        nbits = (diff > 11'd8) ? 4'd8 : diff[3:0];
        mask  = ~(8'hFF << nbits);

        // register pairs
        off    = pos - 16'd9;
        len_m3 = cur_len - 16'd3;
        if (cls == CLS_REGS)
        begin
            lim = {8'd0, cur_count[7:1]};
        end
        else
        begin
            lim = (cur_len >= 16'd3) ? len_m3[15:1] : 15'd0;
        end

        elem_next = cur_elem;
        pend_next = cur_pend;
        v0        = 1'b0;
        r0        = '0;
        r0.unit_id       = cur_unit;
        r0.function_code = f;

        if (hdr_err)
        begin
            v0               = 1'b1;
            r0.kind          = KIND_DONE;
            r0.unit_id       = 8'd0;
            r0.function_code = 7'd0;
            r0.status        = id_err ? ST_ID : ST_PROTO;
            r0.last          = 1'b1;
        end
        else if (pos >= 16'd9 && (func_next & EXC_BIT_MASK) == 8'd0)
        begin
            if (cls == CLS_BITS)
            begin
                if (cur_elem < rx.requested_count)
                begin
                    v0           = 1'b1;
                    r0.kind      = KIND_BITS;
                    r0.value     = {8'd0, b & mask};
                    r0.bit_count = nbits;
                    elem_next    = cur_elem + {7'd0, nbits};
                end
            end
            else if (cls == CLS_REGS || cls == CLS_XREGS)
            begin
                if (!off[0])
                begin
                    pend_next = b;
                end
                else if (off[15:1] < lim)
                begin
                    v0       = 1'b1;
                    r0.kind  = KIND_REG;
                    r0.value = {cur_pend, b};
                end
            end
        end

        end_sum = {1'b0, len_next} + 17'd5;
        end_pos = end_sum[16] ? 16'hFFFF : end_sum[15:0];
        done    = !hdr_err && (pos >= 16'd7) && (pos >= end_pos);

        r1               = '0;
        r1.kind          = KIND_DONE;
        r1.unit_id       = unit_next;
        r1.function_code = f;
        r1.last          = 1'b1;
        if ((func_next & EXC_BIT_MASK) != 8'd0)
        begin
            r1.status     = ST_EXCEPTION;
            r1.error_code = count_next;
        end
        else
        begin
            r1.status = (cls == CLS_UNKNOWN) ? ST_UNKNOWN : ST_OK;
        end

        byte_pos_next = (pos != 16'hFFFF) ? pos + 16'd1 : pos;
        discard_next  = hdr_err || done;

        push_n = push ? ({2'd0, v0} + {2'd0, done}) : '0;
    end

    assign rx.ready = (cnt_reg <= CntW'(FifoDepth - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xread_reg  <= '0;
            xwrite_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EXTRA_READ:  xread_reg  <= cfg_data;
                REG_EXTRA_WRITE: xwrite_reg <= cfg_data;
                default:         xread_reg  <= xread_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            len_reg      <= '0;
            idh_reg      <= '0;
            unit_reg     <= '0;
            func_reg     <= '0;
            count_reg    <= '0;
            elem_reg     <= '0;
            pend_reg     <= '0;
            discard_reg  <= 1'b0;
        end
        else if (push)
        begin
            byte_pos_reg <= byte_pos_next;
            len_reg      <= len_next;
            idh_reg      <= idh_next;
            unit_reg     <= unit_next;
            func_reg     <= func_next;
            count_reg    <= count_next;
            elem_reg     <= elem_next;
            pend_reg     <= pend_next;
            discard_reg  <= discard_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + push_n[PtrW-1:0];
            rp_reg  <= rp_reg + PtrW'(pop);
            cnt_reg <= cnt_reg + push_n - CntW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (v0)
            begin
                fifo_mem[wp_reg] <= r0;
                if (done)
                begin
                    fifo_mem[wp_reg + PtrW'(1)] <= r1;
                end
            end
            else if (done)
            begin
                fifo_mem[wp_reg] <= r1;
            end
        end
    end

    assign res.valid         = (cnt_reg != '0);
    assign res.kind          = fifo_mem[rp_reg].kind;
    assign res.value         = fifo_mem[rp_reg].value;
    assign res.bit_count     = fifo_mem[rp_reg].bit_count;
    assign res.unit_id       = fifo_mem[rp_reg].unit_id;
    assign res.function_code = fifo_mem[rp_reg].function_code;
    assign res.status        = fifo_mem[rp_reg].status;
    assign res.error_code    = fifo_mem[rp_reg].error_code;
    assign res.last          = fifo_mem[rp_reg].last;

endmodule
